// File: hdl/mvpm_pkg.sv
// Shared types, constants and helper functions of the multi-voice PCM mixer.
package mvpm_pkg;

    localparam int VOICE_BITS = 6;
    localparam int ADDR_BITS  = 14;
    localparam int POS_BITS   = 15;
    localparam int GAIN_BITS  = 10;
    localparam int ACC_BITS   = 32;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_START = 3'd1,
        OP_GAIN  = 3'd2,
        OP_STOP  = 3'd3,
        OP_MIX   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_MASTER = 2'd0,
        CFG_EIGHT  = 2'd1,
        CFG_MONO   = 2'd2
    } cfg_index_t;

    // Voice descriptor as stored in the voice memory.
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [POS_BITS-1:0]  position;
        logic [POS_BITS-1:0]  length;
        logic                 loop_on;
        logic [ADDR_BITS-1:0] loop_point;
        logic [GAIN_BITS-1:0] left_gain;
        logic [GAIN_BITS-1:0] right_gain;
        logic                 narrow;
    } voice_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_SCALE,
        ST_CLAMP,
        ST_OUT
    } mix_state_t;

    // Contribution of one voice for one gain; wide samples take a floor shift by 8.
    function automatic logic signed [ACC_BITS-1:0] voice_term(
        input logic [15:0]          word,
        input logic                 narrow,
        input logic [GAIN_BITS-1:0] gain
    );
        logic [7:0]         g8;
        logic signed [27:0] prod;
        logic signed [19:0] p8;
        begin
            g8   = (gain > 10'd255) ? 8'd255 : gain[7:0];
            prod = $signed(word) * $signed({1'b0, gain});
            p8   = $signed(word[7:0]) * $signed({1'b0, g8[7:3], 3'b000});
            if (narrow)
                voice_term = ACC_BITS'(p8);
            else
                voice_term = ACC_BITS'(prod >>> 8);
        end
    endfunction

    // Clamp a scaled sum and format it.
    function automatic logic [15:0] format_out(
        input logic signed [33:0] x,
        input logic               eight
    );
        logic signed [15:0] c;
        begin
            if (x > 34'sd32767)
                c = 16'sd32767;
            else if (x < -34'sd32768)
                c = -16'sd32768;
            else
                c = x[15:0];
            if (eight)
                format_out = {8'd0, c[15:8] ^ 8'h80};
            else
                format_out = c;
        end
    endfunction

endpackage

// File: hdl/multi_voice_pcm_mixer_core.sv
// Top level of the multi-voice PCM mixer: handshakes, memories and frame sequencer.
//
// A load, start, gain or stop word updates the memories or active bits when it
// is taken. A mix-frame word walks all 64 voice descriptors through the voice
// memory, one voice per cycle with one sample-memory read each. The walk is
// followed by a pipeline drain, then the scale, clamp and present steps, and the
// result is then registered; the next word is taken only after the present step.
// The single read port of the voice memory limits the walk. Input is taken only
// while no frame is in work. The result waits in an output register, and a later
// frame holds before its clamp step until that register is free. Sample memory and
// voice slots read as garbage until written. tdata input fields, low bit first:
// opcode, voice_slot, address, sample_word, sound_length, loop_enable,
// loop_point, left_volume, right_volume, narrow_sound.
module multi_voice_pcm_mixer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // opcode, voice_slot, address, sample_word, sound_length, loop_enable,
    // loop_point, left_volume, right_volume, narrow_sound (padding to 96)
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // left_sample, right_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    // Input field unpacking
    logic [2:0]  in_op;
    logic [5:0]  in_slot;
    logic [13:0] in_addr;
    logic [15:0] in_word;
    logic [14:0] in_len;
    logic        in_loop;
    logic [13:0] in_lp;
    logic [9:0]  in_lv;
    logic [9:0]  in_rv;
    logic        in_narrow;

    assign in_op     = s_tdata[2:0];
    assign in_slot   = s_tdata[8:3];
    assign in_addr   = s_tdata[22:9];
    assign in_word   = s_tdata[38:23];
    assign in_len    = s_tdata[53:39];
    assign in_loop   = s_tdata[54];
    assign in_lp     = s_tdata[68:55];
    assign in_lv     = s_tdata[78:69];
    assign in_rv     = s_tdata[88:79];
    assign in_narrow = s_tdata[89];

    // Configuration registers
    logic [9:0] master_reg;
    logic       eight_reg;
    logic       mono_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= 10'd179;
            eight_reg  <= 1'b0;
            mono_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mvpm_pkg::CFG_MASTER: master_reg <= cfg_data;
                mvpm_pkg::CFG_EIGHT:  eight_reg  <= cfg_data[0];
                mvpm_pkg::CFG_MONO:   mono_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Memories
    logic [15:0]           sample_mem [16384];
    mvpm_pkg::voice_t      voice_mem  [64];
    logic [63:0]           active_reg;

    mvpm_pkg::mix_state_t  state_reg, state_next;
    logic [6:0]            vidx_reg;      // voices read so far
    logic [5:0]            fidx_reg;      // voice whose descriptor is in vdat_reg
    logic                  fvalid_reg;
    mvpm_pkg::voice_t      vdat_reg;
    logic [15:0]           sdat_reg;
    mvpm_pkg::voice_t      sdesc_reg;
    logic                  svalid_reg;
    logic signed [31:0]    lacc_reg, racc_reg;
    logic signed [33:0]    lscl_reg, rscl_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;

    logic                  accept;
    logic                  fetch_go;
    logic                  skip;
    logic                  out_free;

    assign s_tready = (state_reg == mvpm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    // Output register can take a new word this cycle
    assign out_free = !out_valid_reg || m_tready;

    // A voice that is active with nonzero gain reads a sample and advances
    assign fetch_go = fvalid_reg && active_reg[fidx_reg] &&
                      (vdat_reg.left_gain != '0 || vdat_reg.right_gain != '0);
    assign skip = 1'b0;

    // Voice memory and sample memory read stages
    always_ff @(posedge clk)
    begin
        vdat_reg <= voice_mem[vidx_reg[5:0]];
        sdat_reg <= sample_mem[vdat_reg.base + vdat_reg.position[13:0]];
        sdesc_reg <= vdat_reg;
    end

    // Next descriptor after advancing one sample
    mvpm_pkg::voice_t adv;
    logic [14:0]      npos;
    logic             stop_voice;
    always_comb
    begin
        adv        = vdat_reg;
        npos       = vdat_reg.position + 15'd1;
        stop_voice = 1'b0;
        adv.position = npos;
        if (npos >= vdat_reg.length)
        begin
            if (vdat_reg.loop_on)
                adv.position = {1'b0, vdat_reg.loop_point};
            else
                stop_voice = 1'b1;
        end
    end

    // Writes to both memories and the active bits
    always_ff @(posedge clk)
    begin
        if (accept && in_op == mvpm_pkg::OP_LOAD)
            sample_mem[in_addr] <= in_word;
        if (accept && in_op == mvpm_pkg::OP_START)
            voice_mem[in_slot] <= '{base: in_addr, position: '0, length: in_len,
                                    loop_on: in_loop, loop_point: in_lp,
                                    left_gain: in_lv, right_gain: in_rv,
                                    narrow: in_narrow};
        else if (accept && in_op == mvpm_pkg::OP_GAIN)
        begin
            voice_mem[in_slot].left_gain  <= in_lv;
            voice_mem[in_slot].right_gain <= in_rv;
        end
        else if (fetch_go)
            voice_mem[fidx_reg] <= adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (accept && in_op == mvpm_pkg::OP_START)
            active_reg[in_slot] <= 1'b1;
        else if (accept && in_op == mvpm_pkg::OP_STOP)
            active_reg[in_slot] <= 1'b0;
        else if (fetch_go && stop_voice)
            active_reg[fidx_reg] <= skip;
    end

    // Frame sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvpm_pkg::ST_IDLE;
            vidx_reg      <= '0;
            fidx_reg      <= '0;
            fvalid_reg    <= 1'b0;
            svalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            svalid_reg <= fetch_go;
            fidx_reg   <= vidx_reg[5:0];
            fvalid_reg <= (state_reg == mvpm_pkg::ST_READ) && !vidx_reg[6];
            if (state_reg == mvpm_pkg::ST_READ && !vidx_reg[6])
                vidx_reg <= vidx_reg + 7'd1;
            else if (state_reg == mvpm_pkg::ST_IDLE)
                vidx_reg <= '0;
            if (state_reg == mvpm_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Accumulate, scale and format
    always_ff @(posedge clk)
    begin
        if (state_reg == mvpm_pkg::ST_IDLE)
        begin
            lacc_reg <= '0;
            racc_reg <= '0;
        end
        else if (svalid_reg)
        begin
            lacc_reg <= lacc_reg + mvpm_pkg::voice_term(sdat_reg, sdesc_reg.narrow,
                                                        sdesc_reg.left_gain);
            racc_reg <= racc_reg + mvpm_pkg::voice_term(sdat_reg, sdesc_reg.narrow,
                                                        sdesc_reg.right_gain);
        end
        if (state_reg == mvpm_pkg::ST_SCALE)
        begin
            lscl_reg <= 34'((lacc_reg * $signed({1'b0, master_reg})) >>> 8);
            rscl_reg <= 34'((racc_reg * $signed({1'b0, master_reg})) >>> 8);
        end
        if (state_reg == mvpm_pkg::ST_CLAMP && out_free)
        begin
            out_data_reg[15:0]  <= mvpm_pkg::format_out(lscl_reg, eight_reg);
            out_data_reg[31:16] <= mono_reg ? 16'd0
                                            : mvpm_pkg::format_out(rscl_reg, eight_reg);
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvpm_pkg::ST_IDLE:  if (accept && in_op == mvpm_pkg::OP_MIX)
                                    state_next = mvpm_pkg::ST_READ;
            mvpm_pkg::ST_READ:  if (vidx_reg[6])
                                    state_next = mvpm_pkg::ST_FETCH;
            mvpm_pkg::ST_FETCH: if (!fvalid_reg && !svalid_reg)
                                    state_next = mvpm_pkg::ST_SCALE;
            mvpm_pkg::ST_SCALE: state_next = mvpm_pkg::ST_CLAMP;
            mvpm_pkg::ST_CLAMP: if (out_free)
                                    state_next = mvpm_pkg::ST_OUT;
            mvpm_pkg::ST_OUT:   state_next = mvpm_pkg::ST_IDLE;
            default:            state_next = mvpm_pkg::ST_IDLE;
        endcase
    end

    // Checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mvpm_pkg::ST_IDLE |-> !s_tready)
        else $error("input taken during frame");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mvpm_pkg::ST_OUT |=> m_tvalid)
        else $error("frame result lost");

endmodule
